>>> rtl/dds_tuning_word_serial_loader_assert.svh
// Assertion helpers for the tuning word loader.
`ifndef DDS_TUNING_WORD_SERIAL_LOADER_ASSERT_SVH
`define DDS_TUNING_WORD_SERIAL_LOADER_ASSERT_SVH

// same-cycle implication
`define DTW_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DTW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/dtw_pkg.sv
package dtw_pkg;

  localparam int XTAL_W      = 31;
  localparam int CTRL_W      = 8;
  localparam int FREQ_W      = 32;
  localparam int WORD_W      = 32;
  localparam int QUOT_BITS   = 33;  // quotient bits below the overflow limit
  localparam int CNT_W       = 6;
  localparam int SERIAL_BITS = WORD_W + CTRL_W;
  localparam int IDX_W       = 6;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 32;

  localparam logic [XTAL_W-1:0] XTAL_RESET = 31'h1900_0000;
  localparam logic [CTRL_W-1:0] CTRL_RESET = 8'h55;

  localparam logic [IDX_W-1:0] LAST_INDEX = 6'd39;

  localparam logic [CFG_IDX_W-1:0] REG_XTAL = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL = 8'd1;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_OVF  = 2'd1;
  localparam logic [1:0] STAT_ZERO = 2'd2;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [1:0]        status;
  } entry_t;

endpackage

>>> rtl/dds_tuning_word_serial_loader.sv
// Tuning word computer and 40-bit serial loader.
// An accepted item takes 33 restoring divide steps, is written to the queue and
// is then loaded into the shifter; it skips the divide steps when it saturates early.
// The shifter sends one bit per pop; the divider takes a new item only when idle
// and runs ahead of the shifter through a 2-entry queue.
// Reset clears the queue and output, crystal 0x1900_0000 (25 * 2^24), control byte 0x55.
`include "dds_tuning_word_serial_loader_assert.svh"

module dds_tuning_word_serial_loader (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [dtw_pkg::FREQ_W-1:0]     frequency,
  output logic                           empty,
  input  logic                           pop,
  output logic                           serial_bit,
  output logic [dtw_pkg::IDX_W-1:0]      bit_index,
  output logic                           last,
  output logic [dtw_pkg::WORD_W-1:0]     tuning_word,
  output logic [1:0]                     status,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dtw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dtw_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [dtw_pkg::XTAL_W-1:0] crystal_frequency;
  logic [dtw_pkg::CTRL_W-1:0] control_byte;

  logic            q_wr;
  logic            q_full;
  logic            q_rd;
  logic            q_empty;
  dtw_pkg::entry_t q_wr_data;
  dtw_pkg::entry_t q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      crystal_frequency <= dtw_pkg::XTAL_RESET;
      control_byte      <= dtw_pkg::CTRL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == dtw_pkg::REG_XTAL) begin
        crystal_frequency <= cfg_data[dtw_pkg::XTAL_W-1:0];
      end
      if (cfg_index == dtw_pkg::REG_CTRL) begin
        control_byte <= cfg_data[dtw_pkg::CTRL_W-1:0];
      end
    end
  end

  dtw_div u_div (
    .clk               (clk),
    .rst               (rst),
    .push              (push),
    .full              (full),
    .frequency         (frequency),
    .crystal_frequency (crystal_frequency),
    .q_full            (q_full),
    .q_wr              (q_wr),
    .q_data            (q_wr_data)
  );

  dtw_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd      (q_rd),
    .rd_data (q_head),
    .empty   (q_empty)
  );

  dtw_ser u_ser (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_rd         (q_rd),
    .control_byte (control_byte),
    .pop          (pop),
    .empty        (empty),
    .serial_bit   (serial_bit),
    .bit_index    (bit_index),
    .last         (last),
    .tuning_word  (tuning_word),
    .status       (status)
  );

  `DTW_ASSERT_NOW(a_sat_word, clk, rst, !empty && status != dtw_pkg::STAT_OK,
                  tuning_word == '1, "saturated status without all-ones word")
  `DTW_ASSERT_NEXT(a_idx_step, clk, rst, pop && !empty && !last,
                   !empty && bit_index == $past(bit_index) + 6'd1,
                   "bit index did not advance by one")
  `DTW_ASSERT_NOW(a_status_code, clk, rst, !empty,
                  status == dtw_pkg::STAT_OK || status == dtw_pkg::STAT_OVF ||
                  status == dtw_pkg::STAT_ZERO, "undefined status code")

endmodule

>>> rtl/dtw_div.sv
module dtw_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic [dtw_pkg::FREQ_W-1:0] frequency,
  input  logic [dtw_pkg::XTAL_W-1:0] crystal_frequency,
  input  logic                       q_full,
  output logic                       q_wr,
  output dtw_pkg::entry_t            q_data
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t                          state;
  logic [dtw_pkg::CNT_W-1:0]       cnt;
  logic [dtw_pkg::XTAL_W-1:0]      rem;
  logic [dtw_pkg::QUOT_BITS-1:0]   quot;
  logic [1:0]                      stat;

  logic                            accept;
  logic                            xtal_zero;
  logic                            too_big;
  logic [dtw_pkg::FREQ_W+2:0]      freq_x8;
  logic [dtw_pkg::XTAL_W:0]        rem_shift;
  logic [dtw_pkg::XTAL_W+1:0]      diff;
  logic                            ge;
  logic [dtw_pkg::WORD_W:0]        rounded;
  logic                            sat;

  assign full   = (state != S_IDLE);
  assign accept = push && (state == S_IDLE);

  // quotient would reach 2^33 when freq*8 >= crystal: saturate right away,
  // otherwise freq*8 is the remainder after all high quotient bits
  assign freq_x8   = {frequency, 3'b000};
  assign xtal_zero = (crystal_frequency == '0);
  assign too_big   = (freq_x8 >= {4'b0000, crystal_frequency});

  assign rem_shift = {rem, 1'b0};
  assign diff      = {1'b0, rem_shift} - {2'b00, crystal_frequency};
  assign ge        = !diff[dtw_pkg::XTAL_W+1];

  assign rounded = {1'b0, quot[dtw_pkg::QUOT_BITS-1:1]}
                 + {{dtw_pkg::WORD_W{1'b0}}, quot[0]};
  assign sat     = (stat != dtw_pkg::STAT_OK) || (&quot);

  assign q_wr        = (state == S_DONE) && !q_full;
  assign q_data.word = sat ? '1 : rounded[dtw_pkg::WORD_W-1:0];
  assign q_data.status = (stat == dtw_pkg::STAT_OK && (&quot)) ? dtw_pkg::STAT_OVF : stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= (xtal_zero || too_big) ? S_DONE : S_RUN;
            cnt   <= dtw_pkg::CNT_W'(dtw_pkg::QUOT_BITS);
          end
        end
        S_RUN: begin
          cnt <= cnt - 1'b1;
          if (cnt == dtw_pkg::CNT_W'(1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!q_full) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rem <= freq_x8[dtw_pkg::XTAL_W-1:0];
      priority if (xtal_zero) begin
        stat <= dtw_pkg::STAT_ZERO;
        quot <= '1;
      end else if (too_big) begin
        stat <= dtw_pkg::STAT_OVF;
        quot <= '1;
      end else begin
        stat <= dtw_pkg::STAT_OK;
        quot <= '0;
      end
    end else if (state == S_RUN) begin
      rem  <= ge ? diff[dtw_pkg::XTAL_W-1:0] : rem_shift[dtw_pkg::XTAL_W-1:0];
      quot <= {quot[dtw_pkg::QUOT_BITS-2:0], ge};
    end
  end

endmodule

>>> rtl/dtw_fifo.sv
module dtw_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  dtw_pkg::entry_t wr_data,
  output logic            full,
  input  logic            rd,
  output dtw_pkg::entry_t rd_data,
  output logic            empty
);

  dtw_pkg::entry_t mem [2];
  logic            wptr;
  logic            rptr;
  logic [1:0]      count;
  logic            do_wr;
  logic            do_rd;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_wr) begin
        wptr <= !wptr;
      end
      if (do_rd) begin
        rptr <= !rptr;
      end
      unique case ({do_wr, do_rd})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wr_data;
    end
  end

endmodule

>>> rtl/dtw_ser.sv
module dtw_ser (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_empty,
  input  dtw_pkg::entry_t            q_head,
  output logic                       q_rd,
  input  logic [dtw_pkg::CTRL_W-1:0] control_byte,
  input  logic                       pop,
  output logic                       empty,
  output logic                       serial_bit,
  output logic [dtw_pkg::IDX_W-1:0]  bit_index,
  output logic                       last,
  output logic [dtw_pkg::WORD_W-1:0] tuning_word,
  output logic [1:0]                 status
);

  logic                              valid;
  logic [dtw_pkg::SERIAL_BITS-1:0]   shreg;
  logic                              take;
  logic                              load;

  assign take  = pop && valid;
  // next word loads as soon as the final bit of the current one goes out
  assign load  = !q_empty && (!valid || (take && last));
  assign q_rd  = load;

  assign empty      = !valid;
  assign serial_bit = shreg[0];
  assign last       = (bit_index == dtw_pkg::LAST_INDEX);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      priority if (load) begin
        valid <= 1'b1;
      end else if (take && last) begin
        valid <= 1'b0;
      end else begin
        valid <= valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      shreg       <= {control_byte, q_head.word};
      bit_index   <= '0;
      tuning_word <= q_head.word;
      status      <= q_head.status;
    end else if (take) begin
      shreg     <= {1'b0, shreg[dtw_pkg::SERIAL_BITS-1:1]};
      bit_index <= bit_index + 1'b1;
    end
  end

endmodule
